// ===== hw/rtl/plir_pkg.sv =====
`timescale 1ns / 1ps

package plir_pkg;

   // Request codes
   localparam logic [1:0] REQ_INSERT  = 2'd0;
   localparam logic [1:0] REQ_REVERSE = 2'd1;
   localparam logic [1:0] REQ_DUMP    = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   localparam int unsigned OUT_WIDTH = 32;
   localparam int unsigned POS_WIDTH = 6;

   // Per-cell update controls
   typedef struct packed {
      logic shift;   // take the left neighbor's value
      logic load;    // take the new element
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/plir_cell.sv =====
`timescale 1ns / 1ps

module plir_cell #(
   parameter int unsigned ELEMENT_WIDTH = 32
) (
   input  logic                         clock,
   input  plir_pkg::cell_ctrl_type      ctrl,
   input  logic [ELEMENT_WIDTH-1:0]     left_value,
   input  logic [ELEMENT_WIDTH-1:0]     new_value,
   output logic [ELEMENT_WIDTH-1:0]     value
);
   import plir_pkg::*;

   logic [ELEMENT_WIDTH-1:0] value_ff;
   logic [ELEMENT_WIDTH-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = new_value;
      end else if (ctrl.shift) begin
         value_in = left_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== hw/rtl/positional_list_insert_reverse.sv =====
`timescale 1ns / 1ps

// Ordered list of up to LIST_DEPTH signed values, held in a row of cells.
//
// Request channel (req_*): req_type selects insert (at 1-based req_position),
// reverse, or dump. Result channel (rsp_*): one beat per insert, reverse or
// empty dump; a dump of a non-empty list gives one beat per entry, in list
// order, with rsp_last_of_run set on the final beat.
//
// Timing: insert, reverse and empty-dump beats are registered in the cycle after
// the request; the first beat of a non-empty dump passes the dump state register
// and then the output register. Throughput: a request can be taken every cycle
// while the receiver keeps up, except during a dump, which gives one beat per
// cycle through the single output register while the receiver keeps up;
// no request is taken until its last beat is loaded.
// Insert shifts all cells above the slot up by one, all at once.
// Reverse only toggles an orientation bit; inserts and dumps map the
// logical position to a physical cell through it.
// Reset clears the entry count, orientation and output valid; cell contents
// are left as they are and are never read before being written.
// When rsp_ready is low the output register holds its beat and req_ready
// drops, so no result is lost.

module positional_list_insert_reverse #(
   parameter int unsigned LIST_DEPTH    = 32,
   parameter int unsigned ELEMENT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [plir_pkg::POS_WIDTH-1:0] req_position,
   input  logic signed [plir_pkg::OUT_WIDTH-1:0] req_element_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic signed [plir_pkg::OUT_WIDTH-1:0] rsp_element_out,
   output logic        rsp_last_of_run
);
   import plir_pkg::*;

   localparam int unsigned CW = $clog2(LIST_DEPTH + 1);             // count width
   localparam int unsigned IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int unsigned PW = ((CW > POS_WIDTH) ? CW : POS_WIDTH) + 1;
   localparam int unsigned XW = (ELEMENT_WIDTH > OUT_WIDTH) ? ELEMENT_WIDTH : OUT_WIDTH;

   // ---------------- state ----------------
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;          // stored order is mirrored
   logic          dumping_ff, dumping_in;
   logic [CW-1:0] dump_idx_ff, dump_idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [OUT_WIDTH-1:0] rsp_element_ff, rsp_element_in;
   logic          rsp_last_ff, rsp_last_in;

   // ---------------- cells ----------------
   logic [ELEMENT_WIDTH-1:0] cell_value [LIST_DEPTH];
   cell_ctrl_type            cell_ctrl  [LIST_DEPTH];
   logic [ELEMENT_WIDTH-1:0] new_value;
   logic signed [XW-1:0]     ext_in;

   // ---------------- request decode ----------------
   logic          req_fire;
   logic          out_free;
   logic [PW-1:0] pos_w;
   logic [PW-1:0] count_p1;
   logic          bad_pos;
   logic          full;
   logic          ins_ok;
   logic [CW-1:0] slot_log;   // logical slot, pos - 1
   logic [CW-1:0] slot_phys;

   // ---------------- dump read ----------------
   logic [CW-1:0]        rd_phys;
   logic [ELEMENT_WIDTH-1:0] rd_value;
   logic signed [XW-1:0] ext_out;
   logic                 dump_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !dumping_ff && out_free;
   assign req_fire  = req_valid && req_ready;

   assign pos_w    = PW'(req_position);
   assign count_p1 = PW'(count_ff) + PW'(1);
   assign bad_pos  = (pos_w == '0) || (pos_w > count_p1);
   assign full     = (count_ff >= CW'(LIST_DEPTH));
   assign ins_ok   = req_fire && (req_type == REQ_INSERT) && !bad_pos && !full;

   // pos - 1 fits in CW bits whenever the position is valid
   assign slot_log  = CW'(pos_w - PW'(1));
   // Mirrored order: logical slot s lands at physical count - s
   assign slot_phys = rev_ff ? (count_ff - slot_log) : slot_log;

   // element_in sign-extended, then kept in the low ELEMENT_WIDTH bits
   assign ext_in    = XW'(req_element_in);
   assign new_value = ext_in[ELEMENT_WIDTH-1:0];

   genvar gi;
   generate
      for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
         logic [ELEMENT_WIDTH-1:0] left_value;

         if (gi == 0) begin : g_head
            assign left_value = '0;
         end else begin : g_body
            assign left_value = cell_value[gi-1];
         end

         always_comb begin
            cell_ctrl[gi].load  = ins_ok && (slot_phys == CW'(gi));
            cell_ctrl[gi].shift = ins_ok && (CW'(gi) > slot_phys);
         end

         plir_cell #(
            .ELEMENT_WIDTH(ELEMENT_WIDTH)
         ) u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl[gi]),
            .left_value (left_value),
            .new_value  (new_value),
            .value      (cell_value[gi])
         );
      end
   endgenerate

   // Dump readout: one cell per beat, walked backwards when mirrored
   assign rd_phys   = rev_ff ? (count_ff - CW'(1) - dump_idx_ff) : dump_idx_ff;
   assign rd_value  = cell_value[rd_phys[IW-1:0]];
   assign ext_out   = XW'($signed(rd_value));
   assign dump_last = (dump_idx_ff == count_ff - CW'(1));

   always_comb begin
      count_in       = count_ff;
      rev_in         = rev_ff;
      dumping_in     = dumping_ff;
      dump_idx_in    = dump_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;

      if (dumping_ff && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = ST_OK;
         rsp_element_in = ext_out[OUT_WIDTH-1:0];
         rsp_last_in    = dump_last;
         dump_idx_in    = dump_idx_ff + CW'(1);
         if (dump_last) begin
            dumping_in = 1'b0;
         end
      end

      if (req_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = ST_OK;
         rsp_element_in = '0;
         rsp_last_in    = 1'b1;
         case (req_type)
            REQ_INSERT: begin
               if (bad_pos) begin
                  rsp_status_in = ST_BADPOS;
               end else if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            REQ_REVERSE: begin
               rev_in = !rev_ff;
            end
            REQ_DUMP: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  // beats come from the dump walk starting next cycle
                  rsp_valid_in = 1'b0;
                  dumping_in   = 1'b1;
                  dump_idx_in  = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rev_ff       <= 1'b0;
         dumping_ff   <= 1'b0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rev_ff       <= rev_in;
         dumping_ff   <= dumping_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_element_out = rsp_element_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // ---------------- assertions ----------------
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(LIST_DEPTH))
      else $error("entry count above depth");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      ins_ok |=> count_ff == $past(count_ff) + CW'(1))
      else $error("good insert did not bump count");

   a_reverse_flip : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_type == REQ_REVERSE) |=> rev_ff != $past(rev_ff))
      else $error("reverse did not flip orientation");

   a_dump_done : assert property (@(posedge clock) disable iff (reset)
      (dumping_ff && out_free && dump_last) |=> !dumping_ff)
      else $error("dump still running after last beat");

endmodule
